// ===== sv/tpt_pkg.sv =====
// Shared constants, types and codes for the tiled palette texture unswizzle block.
`default_nettype none

package tpt_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int TILE_ROWS     = 8;

    localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
    localparam int IDX_W   = 8;
    localparam int ROW_W   = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int COL_W   = 5;
    localparam int TW_W    = 6;
    localparam int ORG_W   = 17;
    localparam int DIM_W   = 16;
    localparam int COLOR_W = 32;

    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_NIBBLE = 2'd1;
    localparam logic [1:0] MODE_BYTE   = 2'd2;

    localparam logic FUNC_PAL = 1'b0;
    localparam logic FUNC_PIX = 1'b1;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    localparam logic [TW_W-1:0] TW_DIRECT = 6'd4;
    localparam logic [TW_W-1:0] TW_NIBBLE = 6'd32;
    localparam logic [TW_W-1:0] TW_BYTE   = 6'd16;

    typedef struct packed {
        logic               valid;
        logic [DIM_W-1:0]   x;
        logic [DIM_W-1:0]   y;
        logic [COLOR_W-1:0] dir_color;
        logic               pal_rd;
        logic [PAL_AW-1:0]  pal_addr;
        logic               last;
        logic               wait_pair;
    } tpt_issue_t;

    typedef struct packed {
        logic               en;
        logic [PAL_AW-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } tpt_pwr_t;

endpackage

`default_nettype wire

// ===== sv/tiled_palette_texture_unswizzle.sv =====
// Top level: config registers, tile walk, palette RAM, read stage and output register.
// Path: walk and palette read into the read stage registers, then the output register. The
// second pixel of a four-bit byte issues from a held nibble when the read stage can take it.
// Throughput: one beat per cycle for palette writes, eight-bit and direct pixels unless the
// output stalls; one walk unit and one read port keep a four-bit byte until both nibbles issue.
// Reset: asynchronous; clears walk and handshake state, config to 1x1 four-bit; no palette clear.
`default_nettype none

module tiled_palette_texture_unswizzle
    import tpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // frame_start, pal_index[7:0], data_word[31:0]
    input  wire logic        s_axis_tuser,  // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // pos_x[15:0], pos_y[15:0], color[31:0]
    output logic             m_axis_tlast
);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [1:0]       mode_reg;

    tpt_issue_t iss;
    tpt_pwr_t   pwr;

    logic               s1_valid_reg, s1_valid_next;
    logic [DIM_W-1:0]   s1_x_reg, s1_y_reg;
    logic [COLOR_W-1:0] s1_dir_reg;
    logic               s1_pal_reg, s1_last_reg, s1_wait_reg;
    logic               out_valid_reg, out_valid_next;
    logic [DIM_W-1:0]   out_x_reg, out_y_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;
    logic [COLOR_W-1:0] pal_rd_data;
    logic               out_free, s1_can, s1_move;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            mode_reg   <= MODE_NIBBLE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_MODE:   mode_reg   <= cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s1_can   = !s1_valid_reg || out_free;
    assign s1_move  = s1_valid_reg && out_free;

    tpt_walk u_walk (
        .clk            (clk),
        .rst_n          (rst_n),
        .image_width    (width_reg),
        .image_height   (height_reg),
        .pixel_mode     (mode_reg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_func        (s_axis_tuser),
        .in_frame_start (s_axis_tdata[0]),
        .in_pal_index   (s_axis_tdata[8:1]),
        .in_data_word   (s_axis_tdata[40:9]),
        .s1_can         (s1_can),
        .iss            (iss),
        .pwr            (pwr)
    );

    tpt_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pwr.en),
        .wr_addr (pwr.addr),
        .wr_data (pwr.data),
        .rd_en   (iss.valid && iss.pal_rd),
        .rd_addr (iss.pal_addr),
        .rd_data (pal_rd_data)
    );

    always_comb
    begin
        s1_valid_next  = iss.valid ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_wait_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (iss.valid)
            begin
                s1_wait_reg <= iss.wait_pair;
            end
            else if (s1_move)
            begin
                s1_wait_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (iss.valid)
        begin
            s1_x_reg    <= iss.x;
            s1_y_reg    <= iss.y;
            s1_dir_reg  <= iss.dir_color;
            s1_pal_reg  <= iss.pal_rd;
            s1_last_reg <= iss.last;
        end
        if (s1_move)
        begin
            out_x_reg     <= s1_x_reg;
            out_y_reg     <= s1_y_reg;
            out_color_reg <= s1_pal_reg ? pal_rd_data : s1_dir_reg;
            // a held first nibble is last only when its sibling yields nothing
            out_last_reg  <= s1_wait_reg ? !iss.valid : s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_color_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

    a_wait_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        s1_wait_reg |-> s1_valid_reg)
        else $error("pair wait flag without a held pixel");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        iss.valid |-> s1_can)
        else $error("read stage overwritten while stalled");

    a_wait_resolves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_wait_reg && out_free) |=> !s1_wait_reg || s1_valid_reg)
        else $error("held first nibble lost");

endmodule

`default_nettype wire

// ===== sv/tpt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module tpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tpt_walk.sv =====
// Tile walk: takes beats, splits nibble pairs, places pixels, issues palette reads, writes.
`default_nettype none

module tpt_walk
    import tpt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [DIM_W-1:0]   image_width,
    input  wire logic [DIM_W-1:0]   image_height,
    input  wire logic [1:0]         pixel_mode,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_func,
    input  wire logic               in_frame_start,
    input  wire logic [IDX_W-1:0]   in_pal_index,
    input  wire logic [COLOR_W-1:0] in_data_word,
    input  wire logic               s1_can,
    output tpt_issue_t              iss,
    output tpt_pwr_t                pwr
);

    logic [ORG_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             done_reg, done_next;
    logic             pend_reg, pend_next;
    logic [3:0]       nib_reg, nib_next;

    logic             accept, restart, acc_pix, pend_fire, pix_go, pend_set;
    logic [ORG_W-1:0] cur_ox, cur_oy, px, py, ox_adv, oy_adv;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             cur_done, hit, wrap_col, wrap_row;
    logic [TW_W-1:0]  tile_w, col_inc;
    logic [ROW_W:0]   row_inc;
    logic [ORG_W-1:0] w_ext, h_ext;
    logic [IDX_W-1:0] idx_sel;
    logic             is_direct, rd_ok, wr_ok;
    logic [ORG_W-1:0] st_ox, st_oy;
    logic [COL_W-1:0] st_col;
    logic [ROW_W-1:0] st_row;
    logic             st_done;

    assign in_ready  = !pend_reg && s1_can;
    assign accept    = in_valid && in_ready;
    assign restart   = accept && in_frame_start;
    assign pend_fire = pend_reg && s1_can;

    assign cur_ox   = restart ? '0 : ox_reg;
    assign cur_oy   = restart ? '0 : oy_reg;
    assign cur_col  = restart ? '0 : col_reg;
    assign cur_row  = restart ? '0 : row_reg;
    assign cur_done = restart ? 1'b0 : done_reg;

    assign acc_pix = accept && (in_func == FUNC_PIX) && !cur_done
                     && (pixel_mode != 2'd3);
    assign pix_go  = acc_pix || pend_fire;

    always_comb
    begin
        unique case (pixel_mode)
            MODE_DIRECT: tile_w = TW_DIRECT;
            MODE_NIBBLE: tile_w = TW_NIBBLE;
            MODE_BYTE:   tile_w = TW_BYTE;
            default:     tile_w = TW_DIRECT;
        endcase
    end

    assign w_ext = {1'b0, image_width};
    assign h_ext = {1'b0, image_height};
    assign px    = cur_ox + ORG_W'(cur_col);
    assign py    = cur_oy + ORG_W'(cur_row);
    assign hit   = (px < w_ext) && (py < h_ext);

    assign col_inc  = {1'b0, cur_col} + TW_W'(1);
    assign wrap_col = col_inc >= tile_w;
    assign row_inc  = {1'b0, cur_row} + (ROW_W + 1)'(1);
    assign wrap_row = row_inc >= (ROW_W + 1)'(TILE_ROWS);
    assign ox_adv   = cur_ox + ORG_W'(tile_w);
    assign oy_adv   = cur_oy + ORG_W'(TILE_ROWS);

    always_comb
    begin
        st_ox   = cur_ox;
        st_oy   = cur_oy;
        st_col  = col_inc[COL_W-1:0];
        st_row  = cur_row;
        st_done = cur_done;
        if (wrap_col)
        begin
            st_col = '0;
            st_row = row_inc[ROW_W-1:0];
            if (wrap_row)
            begin
                st_row = '0;
                if (ox_adv >= w_ext)
                begin
                    st_ox   = '0;
                    st_oy   = oy_adv;
                    st_done = oy_adv >= h_ext;
                end
                else
                begin
                    st_ox   = ox_adv;
                    st_done = cur_oy >= h_ext;
                end
            end
        end
    end

    // first nibble of a byte holds its result until the second one is placed
    assign pend_set = acc_pix && (pixel_mode == MODE_NIBBLE) && !st_done;

    assign idx_sel   = pend_reg ? {4'b0, nib_reg}
                     : (pixel_mode == MODE_NIBBLE) ? {4'b0, in_data_word[3:0]}
                     : in_data_word[IDX_W-1:0];
    assign is_direct = !pend_reg && (pixel_mode == MODE_DIRECT);
    assign rd_ok     = {1'b0, idx_sel} < (IDX_W + 1)'(PALETTE_DEPTH);
    assign wr_ok     = {1'b0, in_pal_index} < (IDX_W + 1)'(PALETTE_DEPTH);

    always_comb
    begin
        iss.valid     = pix_go && hit;
        iss.x         = px[DIM_W-1:0];
        iss.y         = py[DIM_W-1:0];
        iss.dir_color = is_direct ? in_data_word : '0;
        iss.pal_rd    = !is_direct && rd_ok;
        iss.pal_addr  = idx_sel[PAL_AW-1:0];
        iss.last      = !pend_set;
        iss.wait_pair = pend_set;
    end

    always_comb
    begin
        pwr.en   = accept && (in_func == FUNC_PAL) && wr_ok;
        pwr.addr = in_pal_index[PAL_AW-1:0];
        pwr.data = in_data_word;
    end

    always_comb
    begin
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        done_next = done_reg;
        if (pix_go)
        begin
            ox_next   = st_ox;
            oy_next   = st_oy;
            col_next  = st_col;
            row_next  = st_row;
            done_next = st_done;
        end
        else if (restart)
        begin
            ox_next   = '0;
            oy_next   = '0;
            col_next  = '0;
            row_next  = '0;
            done_next = 1'b0;
        end
        pend_next = pend_set ? 1'b1 : (pend_fire ? 1'b0 : pend_reg);
        nib_next  = pend_set ? in_data_word[7:4] : nib_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg   <= '0;
            oy_reg   <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            done_reg <= done_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nib_reg <= nib_next;
    end

    a_pend_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !in_ready)
        else $error("input taken while a nibble pair is in progress");

    a_pend_only_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (pixel_mode == MODE_NIBBLE))
        else $error("second nibble pending outside four-bit mode");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for tiled_palette_texture_unswizzle: driver, predictor, monitor.
module tb;
    import tpt_pkg::*;

    localparam logic [1:0] MODE_RSVD = 2'd3;

    typedef struct {
        logic        func;
        logic        frame_start;
        logic [7:0]  pal_index;
        logic [31:0] data_word;
    } beat_t;

    typedef struct {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [31:0] color;
        logic        last;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_WIDTH;
    logic [15:0] cfg_data = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = 48'd0;  // frame_start, pal_index[7:0], data_word[31:0]
    logic        s_axis_tuser = FUNC_PAL;  // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;  // pos_x[15:0], pos_y[15:0], color[31:0]
    logic        m_axis_tlast;

    tiled_palette_texture_unswizzle dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    beat_t  beat_q[$];
    pixel_t pixel_q[$];
    beat_t  cur_beat;
    int     errors = 0;
    int     sent = 0;
    int     cyc = 0;
    logic   calm;

    // predictor state
    logic [31:0] pal_mem [PALETTE_DEPTH];
    logic [15:0] img_w = 16'd1;
    logic [15:0] img_h = 16'd1;
    logic [1:0]  pix_mode = MODE_NIBBLE;
    logic [16:0] org_x = '0;
    logic [16:0] org_y = '0;
    logic [5:0]  col = '0;
    logic [3:0]  row = '0;
    logic        frame_over = 1'b0;

    // generator view of loaded palette entries
    bit known [PALETTE_DEPTH];

    assign calm = (cyc >= 1500 && cyc < 2600);

    always @(posedge clk) cyc <= cyc + 1;

    function automatic int walk_pixel(logic [31:0] c, logic [5:0] tw);
        logic [17:0] px;
        logic [17:0] py;
        int hit;
        pixel_t p;
        px = org_x + col;
        py = org_y + row;
        hit = 0;
        if (px < img_w && py < img_h) begin
            p = '{px[15:0], py[15:0], c, 1'b0};
            pixel_q.insert(pixel_q.size(), p);
            hit = 1;
        end
        col = col + 1;
        if (col >= tw) begin
            col = '0;
            row = row + 1;
            if (row >= TILE_ROWS) begin
                row = '0;
                org_x = org_x + tw;
                if (org_x >= img_w) begin
                    org_x = '0;
                    org_y = org_y + TILE_ROWS;
                end
                if (org_y >= img_h)
                    frame_over = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void unswizzle_item(beat_t b);
        int n;
        n = 0;
        if (b.frame_start) begin
            org_x = '0;
            org_y = '0;
            col = '0;
            row = '0;
            frame_over = 1'b0;
        end
        if (b.func == FUNC_PAL) begin
            pal_mem[b.pal_index] = b.data_word;
            return;
        end
        if (frame_over)
            return;
        case (pix_mode)
            MODE_DIRECT: n += walk_pixel(b.data_word, TW_DIRECT);
            MODE_NIBBLE:
            begin
                n += walk_pixel(pal_mem[b.data_word[3:0]], TW_NIBBLE);
                if (!frame_over)
                    n += walk_pixel(pal_mem[b.data_word[7:4]], TW_NIBBLE);
            end
            MODE_BYTE: n += walk_pixel(pal_mem[b.data_word[7:0]], TW_BYTE);
            default: ;
        endcase
        if (n > 0)
            pixel_q[pixel_q.size() - 1].last = 1'b1;
    endfunction

    task automatic check_pixel();
        pixel_t got;
        pixel_t want;
        got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[63:32], m_axis_tlast};
        if (pixel_q.size() == 0) begin
            if (errors < 10)
                $display("unexpected pixel x=%0d y=%0d color=%h last=%b",
                         got.pos_x, got.pos_y, got.color, got.last);
            errors++;
        end else begin
            want = pixel_q.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.color !== want.color || got.last !== want.last) begin
                if (errors < 10)
                    $display({"bad pixel: got x=%0d y=%0d color=%h last=%b,",
                              " want x=%0d y=%0d color=%h last=%b"},
                             got.pos_x, got.pos_y, got.color, got.last,
                             want.pos_x, want.pos_y, want.color, want.last);
                errors++;
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                unswizzle_item(cur_beat);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (beat_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
                    cur_beat = beat_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cur_beat.func;
                    s_axis_tdata  <= {7'd0, cur_beat.data_word, cur_beat.pal_index,
                                      cur_beat.frame_start};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_pixel();
            m_axis_tready <= calm || $urandom_range(99) >= 9;
        end
    end

    task automatic pal_load(logic [7:0] idx, logic [31:0] word, logic start);
        beat_t b;
        b = '{FUNC_PAL, start, idx, word};
        beat_q.insert(beat_q.size(), b);
        known[idx] = 1'b1;
        sent++;
    endtask

    task automatic pix(logic [31:0] word, logic start);
        beat_t b;
        b = '{FUNC_PIX, start, 8'($urandom()), word};
        beat_q.insert(beat_q.size(), b);
        sent++;
    endtask

    function automatic logic [7:0] known_index(logic [7:0] lim);
        logic [7:0] k;
        repeat (40) begin
            k = 8'($urandom_range(lim));
            if (known[k])
                return k;
        end
        return 8'h00;
    endfunction

    function automatic logic [31:0] pixel_word(logic [1:0] m);
        logic [31:0] w;
        logic [7:0]  a;
        logic [7:0]  b;
        w = $urandom();
        a = known_index(8'd15);
        b = known_index(8'd15);
        case (m)
            MODE_DIRECT: ;
            MODE_BYTE: w[7:0] = known_index(8'hFF);
            default: w[7:0] = {b[3:0], a[3:0]};
        endcase
        return w;
    endfunction

    task automatic drain();
        do
            @(negedge clk);
        while (beat_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  img_w = val;
            CFG_HEIGHT: img_h = val;
            default:    pix_mode = val[1:0];
        endcase
        @(negedge clk);
    endtask

    task automatic setup(logic [15:0] w, logic [15:0] h, logic [1:0] m);
        drain();
        reg_write(CFG_WIDTH, w);
        reg_write(CFG_HEIGHT, h);
        reg_write(CFG_MODE, {14'd0, m});
    endtask

    task automatic random_frame();
        logic [15:0] w;
        logic [15:0] h;
        logic [1:0]  m;
        logic [7:0]  idx;
        int n;
        case ($urandom_range(9))
            0:
            begin
                w = 16'hFFFF;
                h = 16'($urandom_range(1, 16));
            end
            1:
            begin
                w = 16'($urandom_range(1, 40));
                h = 16'hFFFF;
            end
            2:
            begin
                w = 16'($urandom_range(1, 4));
                h = 16'($urandom_range(1, 8));
            end
            3:
            begin
                w = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 64));
                h = (w == 16'd0) ? 16'($urandom_range(1, 16)) : 16'd0;
            end
            default:
            begin
                w = 16'($urandom_range(1, 80));
                h = 16'($urandom_range(1, 24));
            end
        endcase
        m = ($urandom_range(99) < 4) ? MODE_RSVD : 2'($urandom_range(2));
        setup(w, h, m);
        repeat ($urandom_range(2, 10)) begin
            idx = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom());
            pal_load(idx, $urandom(), 1'b0);
        end
        pix(pixel_word(m), 1'b1);
        n = $urandom_range(20, 110);
        repeat (n) begin
            if ($urandom_range(99) < 6)
                pal_load(8'($urandom()), $urandom(), $urandom_range(99) < 10);
            else
                pix(pixel_word(m), $urandom_range(99) < 3);
        end
        // switch mode without restarting the walk
        if ($urandom_range(3) == 0) begin
            drain();
            m = 2'($urandom_range(2));
            reg_write(CFG_MODE, {14'd0, m});
            repeat ($urandom_range(20, 60))
                pix(pixel_word(m), 1'b0);
        end
    endtask

    initial begin
        #2400000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: width 1, height 1, four-bit
        pal_load(8'h00, 32'h0000_0000, 1'b1);
        pal_load(8'h0F, 32'hFFFF_FFFF, 1'b0);
        pal_load(8'hF0, 32'h8000_0001, 1'b0);
        pal_load(8'hFF, 32'hA5C3_5A3C, 1'b0);
        pal_load(8'h01, 32'h7FFF_FFFE, 1'b0);
        pix(32'hFFFF_FFF0, 1'b0);
        pix(32'h0000_000F, 1'b1);

        setup(16'hFFFF, 16'hFFFF, MODE_BYTE);
        pix(32'h0000_00FF, 1'b1);
        pix(32'hFFFF_FF00, 1'b0);
        pix(32'h0000_00F0, 1'b0);
        pix(32'h0000_000F, 1'b0);
        pal_load(8'h55, 32'h1234_5678, 1'b1);
        pix(32'h0000_0001, 1'b0);
        pix(32'hFFFF_FF55, 1'b0);
        pix(32'h0000_00FF, 1'b0);
        pix(32'h5555_5500, 1'b0);
        pix(32'hAAAA_AA0F, 1'b0);
        pix(32'h0000_00F0, 1'b0);

        // column already past the direct-mode tile width
        drain();
        reg_write(CFG_MODE, {14'd0, MODE_DIRECT});
        pix(32'h0000_0000, 1'b0);
        pix(32'hFFFF_FFFF, 1'b0);
        pix(32'hDEAD_BEEF, 1'b0);

        drain();
        reg_write(CFG_MODE, {14'd0, MODE_RSVD});
        pix(32'h1234_5600, 1'b0);
        pal_load(8'h10, 32'hCAFE_F00D, 1'b0);

        // odd alignment: first nibble of a byte ends the frame
        setup(16'd1, 16'd1, MODE_BYTE);
        pix(32'h0000_0000, 1'b1);
        drain();
        reg_write(CFG_MODE, {14'd0, MODE_NIBBLE});
        repeat (130)
            pix(pixel_word(MODE_NIBBLE), 1'b0);
        pix(pixel_word(MODE_NIBBLE), 1'b1);

        while (sent < 1420)
            random_frame();

        drain();
        repeat (8) @(negedge clk);
        if (errors == 0 && pixel_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== tiled_palette_texture_unswizzle.f =====
sv/tpt_pkg.sv
sv/tpt_ram.sv
sv/tpt_walk.sv
sv/tiled_palette_texture_unswizzle.sv
sim/tb.sv
